FILE: src/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants for the IR pulse-distance frame decoder
// Holds register codes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned FRAME_BITS_DEF = 32;
  localparam int unsigned INTERVAL_W     = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned FRAME_W        = 32;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [INTERVAL_W-1:0] interval_t;

  localparam cfg_idx_t REG_HEADER_MIN = 3'd0;
  localparam cfg_idx_t REG_HEADER_MAX = 3'd1;
  localparam cfg_idx_t REG_SHORT_MIN  = 3'd2;
  localparam cfg_idx_t REG_BIT_SPLIT  = 3'd3;
  localparam cfg_idx_t REG_LONG_MAX   = 3'd4;

  localparam interval_t HEADER_MIN_RST = 16'd8000;
  localparam interval_t HEADER_MAX_RST = 16'd14000;
  localparam interval_t SHORT_MIN_RST  = 16'd700;
  localparam interval_t BIT_SPLIT_RST  = 16'd1450;
  localparam interval_t LONG_MAX_RST   = 16'd3000;

  typedef struct packed {
    interval_t header_min;
    interval_t header_max;
    interval_t short_min;
    interval_t bit_split;
    interval_t long_max;
  } ipd_cfg_t;

  // Window hits for one interval
  typedef struct packed {
    logic hdr;
    logic one;
    logic zero;
  } ipd_class_t;

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] command_check_byte;
    logic [7:0] command_byte;
    logic [7:0] address_check_byte;
    logic [7:0] address_byte;
  } ipd_result_t;

  typedef struct packed {
    logic       receiving;
    logic [5:0] bit_count;
  } ipd_status_t;

endpackage

FILE: src/ir_pulse_distance_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_unit: NEC-style IR frame decoder
// Decodes receiver edge intervals into 32-bit frames with a check flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in_     | slave     | in_tvalid/in_tready | tdata[15:0] edge_interval
//  out_    | master    | out_tvalid/tready   | tdata 4 frame bytes, tuser ok
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data[15:0]
//
// One transaction per cycle while the output does not stall: an interval lands
// in the input register, then the window compare and frame update run
// combinationally into the output register.
// Reset (synchronous, rst_n low) restores the default windows and goes idle.
// A stalled result holds the output register; the input register then holds
// and in_tready drops only once both registers are full.
// cfg_ready is always high; writes are expected while the block is idle.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_unit import ipd_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] edge_interval
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [7:0] address_byte,
                                            // [15:8] address_check_byte,
                                            // [23:16] command_byte,
                                            // [31:24] command_check_byte
  output logic                  out_tuser,  // [0] frame_ok
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  ipd_cfg_t    cfg_r;
  logic        in_valid_r;
  interval_t   in_data_r;
  logic        out_valid_r;
  ipd_result_t out_data_r;
  logic        proc;
  ipd_class_t  cls;
  logic        res_valid;
  ipd_result_t res;
  ipd_status_t status;

  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_min <= HEADER_MIN_RST;
      cfg_r.header_max <= HEADER_MAX_RST;
      cfg_r.short_min  <= SHORT_MIN_RST;
      cfg_r.bit_split  <= BIT_SPLIT_RST;
      cfg_r.long_max   <= LONG_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_MIN: cfg_r.header_min <= cfg_data;
        REG_HEADER_MAX: cfg_r.header_max <= cfg_data;
        REG_SHORT_MIN:  cfg_r.short_min  <= cfg_data;
        REG_BIT_SPLIT:  cfg_r.bit_split  <= cfg_data;
        REG_LONG_MAX:   cfg_r.long_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held interval whenever the output slot is free or draining
  assign proc      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  ipd_classify u_classify (
    .cfg      (cfg_r),
    .interval (in_data_r),
    .cls      (cls)
  );

  ipd_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (proc),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // Result register: load a finished frame, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.command_check_byte, out_data_r.command_byte,
                       out_data_r.address_check_byte, out_data_r.address_byte};
  assign out_tuser  = out_data_r.frame_ok;

`ifndef NO_ASSERTIONS
  // A result only loads when the output slot is free or being taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending output");

  // Completing a frame returns the assembler to idle
  a_idle_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !status.receiving && (status.bit_count == 6'd0))
    else $error("assembler still receiving after frame");

  // The bit counter never reaches the frame length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.bit_count < 6'(FRAME_BITS))
    else $error("bit counter out of range");

  // A held interval keeps its value while the output stalls
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proc) |=> (in_valid_r && $stable(in_data_r)))
    else $error("input register lost a stalled interval");
`endif

endmodule

FILE: src/ipd_classify.sv
// ----------------------------------------------------------------------------
// ipd_classify: interval window compare
// Tests one edge interval against the header, zero and one windows.
// ----------------------------------------------------------------------------
module ipd_classify import ipd_pkg::*; (
  input  ipd_cfg_t   cfg,
  input  interval_t  interval,
  output ipd_class_t cls
);

  // All bounds are exclusive
  assign cls.hdr  = (interval > cfg.header_min) && (interval < cfg.header_max);
  assign cls.one  = (interval > cfg.bit_split)  && (interval < cfg.long_max);
  assign cls.zero = (interval > cfg.short_min)  && (interval < cfg.bit_split);

endmodule

FILE: src/ipd_frame.sv
// ----------------------------------------------------------------------------
// ipd_frame: frame assembler
// Tracks the receive state, shifts bits into byte lanes and flags a full frame.
// ----------------------------------------------------------------------------
module ipd_frame import ipd_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  ipd_class_t  cls,
  output logic        res_valid,
  output ipd_result_t res,
  output ipd_status_t status
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);

  logic             receiving_r, receiving_nxt;
  logic [CNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [CNT_W-1:0] count_inc;
  logic [5:0]       count_ext;
  logic [1:0]       lane;
  logic             take_bit;

  assign count_ext = 6'(bit_count_r);
  assign lane      = count_ext[4:3];
  assign count_inc = bit_count_r + 1'b1;
  assign take_bit  = receiving_r && (cls.one || cls.zero);

  always_comb begin
    receiving_nxt = receiving_r;
    bit_count_nxt = bit_count_r;
    frame_nxt     = frame_r;
    res_valid     = 1'b0;
    if (en && cls.hdr) begin
      receiving_nxt = 1'b1;
      bit_count_nxt = '0;
    end else if (en && take_bit) begin
      // Shift the active byte right, new bit into its top
      for (int l = 0; l < 4; l++) begin
        if (lane == 2'(l)) begin
          frame_nxt[l*8 +: 8] = {cls.one, frame_r[l*8+1 +: 7]};
        end
      end
      if (count_inc == CNT_W'(FRAME_BITS)) begin
        bit_count_nxt = '0;
        receiving_nxt = 1'b0;
        res_valid     = 1'b1;
      end else begin
        bit_count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      bit_count_r <= '0;
      frame_r     <= '0;
    end else begin
      receiving_r <= receiving_nxt;
      bit_count_r <= bit_count_nxt;
      frame_r     <= frame_nxt;
    end
  end

  assign res.address_byte       = frame_nxt[7:0];
  assign res.address_check_byte = frame_nxt[15:8];
  assign res.command_byte       = frame_nxt[23:16];
  assign res.command_check_byte = frame_nxt[31:24];
  assign res.frame_ok           = (frame_nxt[23:16] == ~frame_nxt[31:24]);

  assign status.receiving = receiving_r;
  assign status.bit_count = 6'(bit_count_r);

endmodule
